>>> hdl/rbid_pkg.sv
// Shared types and constants for the rotating bitmap identifier allocator.
package rbid_pkg;

   // Width of the identifier fields on the request and result channels.
   localparam int ID_BITS = 13;

   // Lowest identifier that may ever be granted; 0 and 1 stay reserved.
   localparam int FIRST_FREE_ID = 2;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [ID_BITS-1:0] release_id;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] granted_id;
      logic               ok;
   } rsp_type;

   // Which result the datapath loads into its result register.
   typedef enum logic [2:0] {
      RSP_NONE     = 3'd0,
      RSP_GRANT    = 3'd1,
      RSP_ECHO_OK  = 3'd2,
      RSP_ECHO_BAD = 3'd3,
      RSP_FAIL     = 3'd4
   } rsp_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         clear_step;
      logic         load_req;
      logic         scan_start;
      logic         scan_eval;
      logic         alloc_commit;
      logic         cursor_adv;
      logic         div_quot;
      logic         div_rem;
      logic         rd_word;
      logic         release_commit;
      rsp_kind_type rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic is_release;
      logic rel_in_range;
      logic hit;
      logic scan_final;
   } dp_sts_type;

endpackage

>>> hdl/rbid_datapath.sv
// Datapath of the allocator: occupancy memory, cursor, word scan, divider and result register.
module rbid_datapath #(
   parameter int ID_COUNT      = 8192,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  rbid_pkg::req_type    req_data,
   input  rbid_pkg::dp_cmd_type cmd,
   output rbid_pkg::dp_sts_type sts,
   output logic                rsp_strobe,
   output rbid_pkg::rsp_type    rsp_data
);
   import rbid_pkg::*;

   localparam int MAP_WORDS = (ID_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int ID_W      = $clog2(ID_COUNT);
   localparam int LAST_IDX  = MAP_WORDS - 1;
   localparam int LAST_BITS = ID_COUNT - LAST_IDX * MAP_WORD_BITS;
   localparam int GROUPS    = (MAP_WORD_BITS + 7) / 8;
   localparam int PAD_W     = GROUPS * 8;
   localparam int DIV_SHIFT = ID_BITS + BIT_W;
   localparam int RECIP     = ((2 ** DIV_SHIFT) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int RECIP_W   = ID_BITS + 2;
   localparam int PROD_W    = ID_BITS + RECIP_W;
   localparam int REM_W     = ID_BITS + BIT_W + 1;

   localparam logic [WORD_W-1:0] LAST_WORD  = WORD_W'(LAST_IDX);
   localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(LAST_BITS - 1);
   localparam logic [BIT_W-1:0]  TOP_BIT    = BIT_W'(MAP_WORD_BITS - 1);
   localparam logic [BIT_W-1:0]  FIRST_BIT  = BIT_W'(FIRST_FREE_ID);
   localparam logic [ID_W-1:0]   WORD_STEP  = ID_W'(MAP_WORD_BITS);

   logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] rd_data_ff;

   logic [WORD_W-1:0]  clr_addr_ff,  clr_addr_in;
   logic [WORD_W-1:0]  cur_word_ff,  cur_word_in;
   logic [BIT_W-1:0]   cur_bit_ff,   cur_bit_in;
   logic [ID_W-1:0]    cur_base_ff,  cur_base_in;
   logic [WORD_W-1:0]  scan_word_ff, scan_word_in;
   logic [ID_W-1:0]    scan_base_ff, scan_base_in;
   logic               first_ff,     first_in;
   logic               final_ff,     final_in;
   logic [BIT_W-1:0]   hit_idx_ff,   hit_idx_in;
   logic [ID_BITS-1:0] rid_ff,       rid_in;
   logic [ID_BITS-1:0] quot_ff,      quot_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff,       rsp_in;

   logic [PAD_W-1:0]   free_pad;
   logic [GROUPS-1:0]  grp_any;
   logic [2:0]         grp_idx [GROUPS];
   logic [BIT_W-1:0]   enc_idx;
   logic               enc_hit;

   logic [WORD_W-1:0]  src_word, nxt_word, scan_nxt_word;
   logic [BIT_W-1:0]   src_bit,  nxt_bit;
   logic [ID_W-1:0]    src_base, nxt_base, scan_nxt_base;

   logic [PROD_W-1:0]  quot_prod;
   logic [REM_W-1:0]   rem_val;

   logic               rd_en, wr_en;
   logic [WORD_W-1:0]  rd_addr, wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data, hit_mask;

   // Free slots of the current word that this visit may grant, then the lowest one.
   always_comb begin
      free_pad = '0;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         free_pad[b] = ~rd_data_ff[b]
            & (!first_ff || (BIT_W'(b) >= cur_bit_ff))
            & (!final_ff || (BIT_W'(b) <  cur_bit_ff))
            & !((scan_word_ff == '0) && (b < FIRST_FREE_ID))
            & !((scan_word_ff == LAST_WORD) && (b >= LAST_BITS));
      end
      for (int g = 0; g < GROUPS; g++) begin
         grp_any[g] = |free_pad[g*8 +: 8];
         grp_idx[g] = '0;
         for (int i = 7; i >= 0; i--) begin
            if (free_pad[g*8 + i]) begin
               grp_idx[g] = 3'(i);
            end
         end
      end
      enc_idx = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            enc_idx = BIT_W'(g * 8) + BIT_W'(grp_idx[g]);
         end
      end
   end

   assign enc_hit = |grp_any;

   // Cursor step: one place forward, wrapping from the last identifier to the first free one.
   always_comb begin
      if (cmd.alloc_commit) begin
         src_word = scan_word_ff;
         src_bit  = hit_idx_ff;
         src_base = scan_base_ff;
      end else begin
         src_word = cur_word_ff;
         src_bit  = cur_bit_ff;
         src_base = cur_base_ff;
      end
      if ((src_word == LAST_WORD) && (src_bit == LAST_BIT)) begin
         nxt_word = '0;
         nxt_bit  = FIRST_BIT;
         nxt_base = '0;
      end else if (src_bit == TOP_BIT) begin
         nxt_word = src_word + 1'b1;
         nxt_bit  = '0;
         nxt_base = src_base + WORD_STEP;
      end else begin
         nxt_word = src_word;
         nxt_bit  = src_bit + 1'b1;
         nxt_base = src_base;
      end
   end

   always_comb begin
      if (scan_word_ff == LAST_WORD) begin
         scan_nxt_word = '0;
         scan_nxt_base = '0;
      end else begin
         scan_nxt_word = scan_word_ff + 1'b1;
         scan_nxt_base = scan_base_ff + WORD_STEP;
      end
   end

   // Release identifier split into word and bit by a reciprocal multiply, exact for 13-bit ids.
   assign quot_prod = PROD_W'(rid_ff) * PROD_W'(RECIP);
   assign rem_val   = REM_W'(rid_ff) - (REM_W'(quot_ff) * REM_W'(MAP_WORD_BITS));

   assign hit_mask = MAP_WORD_BITS'(1) << hit_idx_ff;

   always_comb begin
      rd_en   = cmd.scan_start | (cmd.scan_eval & !enc_hit) | cmd.rd_word;
      rd_addr = scan_word_ff;
      if (cmd.scan_start) begin
         rd_addr = cur_word_ff;
      end else if (cmd.scan_eval) begin
         rd_addr = scan_nxt_word;
      end
      wr_en   = cmd.clear_step | cmd.alloc_commit | cmd.release_commit;
      wr_addr = cmd.clear_step ? clr_addr_ff : scan_word_ff;
      if (cmd.alloc_commit) begin
         wr_data = rd_data_ff | hit_mask;
      end else if (cmd.release_commit) begin
         wr_data = rd_data_ff & ~hit_mask;
      end else begin
         wr_data = '0;
      end
   end

   always_comb begin
      clr_addr_in   = clr_addr_ff;
      cur_word_in   = cur_word_ff;
      cur_bit_in    = cur_bit_ff;
      cur_base_in   = cur_base_ff;
      scan_word_in  = scan_word_ff;
      scan_base_in  = scan_base_ff;
      first_in      = first_ff;
      final_in      = final_ff;
      hit_idx_in    = hit_idx_ff;
      rid_in        = rid_ff;
      quot_in       = quot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
      if (cmd.load_req) begin
         rid_in = req_data.release_id;
      end
      if (cmd.scan_start) begin
         scan_word_in = cur_word_ff;
         scan_base_in = cur_base_ff;
         first_in     = 1'b1;
         final_in     = 1'b0;
      end
      if (cmd.scan_eval) begin
         if (enc_hit) begin
            hit_idx_in = enc_idx;
         end else begin
            scan_word_in = scan_nxt_word;
            scan_base_in = scan_nxt_base;
            first_in     = 1'b0;
            final_in     = (scan_nxt_word == cur_word_ff);
         end
      end
      if (cmd.alloc_commit || cmd.cursor_adv) begin
         cur_word_in = nxt_word;
         cur_bit_in  = nxt_bit;
         cur_base_in = nxt_base;
      end
      if (cmd.div_quot) begin
         quot_in = ID_BITS'(quot_prod >> DIV_SHIFT);
      end
      if (cmd.div_rem) begin
         scan_word_in = WORD_W'(quot_ff);
         hit_idx_in   = BIT_W'(rem_val);
      end

      unique case (cmd.rsp)
         RSP_NONE: begin
         end
         RSP_GRANT: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.granted_id = ID_BITS'(scan_base_ff + ID_W'(hit_idx_ff));
            rsp_in.ok         = 1'b1;
         end
         RSP_ECHO_OK: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.granted_id = rid_ff;
            rsp_in.ok         = 1'b1;
         end
         RSP_ECHO_BAD: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.granted_id = rid_ff;
            rsp_in.ok         = 1'b0;
         end
         RSP_FAIL: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.granted_id = '0;
            rsp_in.ok         = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         cur_word_ff   <= '0;
         cur_bit_ff    <= FIRST_BIT;
         cur_base_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_addr_ff   <= clr_addr_in;
         cur_word_ff   <= cur_word_in;
         cur_bit_ff    <= cur_bit_in;
         cur_base_ff   <= cur_base_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_word_ff <= scan_word_in;
      scan_base_ff <= scan_base_in;
      first_ff     <= first_in;
      final_ff     <= final_in;
      hit_idx_ff   <= hit_idx_in;
      rid_ff       <= rid_in;
      quot_ff      <= quot_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.clear_done   = (clr_addr_ff == LAST_WORD);
   assign sts.is_release   = (req_data.opcode == OP_RELEASE);
   assign sts.rel_in_range = (32'(req_data.release_id) >= 32'(FIRST_FREE_ID))
                           && (32'(req_data.release_id) < 32'(ID_COUNT));
   assign sts.hit          = enc_hit;
   assign sts.scan_final   = final_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> hdl/rbid_ctrl.sv
// Controller state machine of the allocator.
module rbid_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rbid_pkg::dp_sts_type sts,
   output rbid_pkg::dp_cmd_type cmd,
   output logic                busy
);
   import rbid_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_SCAN     = 11'b000_0000_0100,
      S_ALLOC_WR = 11'b000_0000_1000,
      S_FAIL_A   = 11'b000_0001_0000,
      S_FAIL_B   = 11'b000_0010_0000,
      S_DIV_Q    = 11'b000_0100_0000,
      S_DIV_R    = 11'b000_1000_0000,
      S_REL_RD   = 11'b001_0000_0000,
      S_REL_WR   = 11'b010_0000_0000,
      S_REJECT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp  = RSP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               if (!sts.is_release) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else if (sts.rel_in_range) begin
                  state_in = S_DIV_Q;
               end else begin
                  state_in = S_REJECT;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_eval = 1'b1;
            if (sts.hit) begin
               state_in = S_ALLOC_WR;
            end else if (sts.scan_final) begin
               state_in = S_FAIL_A;
            end
         end
         S_ALLOC_WR: begin
            cmd.alloc_commit = 1'b1;
            cmd.rsp          = RSP_GRANT;
            state_in         = S_IDLE;
         end
         S_FAIL_A: begin
            cmd.cursor_adv = 1'b1;
            state_in       = S_FAIL_B;
         end
         S_FAIL_B: begin
            cmd.cursor_adv = 1'b1;
            cmd.rsp        = RSP_FAIL;
            state_in       = S_IDLE;
         end
         S_DIV_Q: begin
            cmd.div_quot = 1'b1;
            state_in     = S_DIV_R;
         end
         S_DIV_R: begin
            cmd.div_rem = 1'b1;
            state_in    = S_REL_RD;
         end
         S_REL_RD: begin
            cmd.rd_word = 1'b1;
            state_in    = S_REL_WR;
         end
         S_REL_WR: begin
            cmd.release_commit = 1'b1;
            cmd.rsp            = RSP_ECHO_OK;
            state_in           = S_IDLE;
         end
         S_REJECT: begin
            cmd.rsp  = RSP_ECHO_BAD;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> hdl/rotating_bitmap_id_allocator.sv
// Top level of the rotating next-fit bitmap identifier allocator.
//
//   Channel   Ports                           Direction  Transfer
//   request   start, busy, req_data           in         start high while busy is low
//   result    rsp_strobe, rsp_data            out        every cycle rsp_strobe is high
//
// After reset the block sweeps the occupancy memory clear, one word per cycle, over all
// ceil(ID_COUNT / MAP_WORD_BITS) words (128 with the defaults); busy stays high
// meanwhile. An allocate scans the bitmap words, one word per cycle from the single memory
// read port, and its result follows the scan; a full map reads every word plus the
// starting word again and then steps the cursor one place in S_FAIL_A and one more in
// S_FAIL_B before the failure result. A release in range runs the word/bit split
// (quotient, then remainder), one read and one write; an out-of-range one goes to S_REJECT.
// Results are never held off by the receiver, so busy depends only on the work.
//
// The occupancy bitmap lives in one memory of MAP_WORD_BITS-wide words. The search
// cursor is kept as a word index, a bit index and the identifier of the word's
// first bit, so the scan needs no division. Identifiers 0 and 1 are never granted:
// they are masked out of word 0, and releases of them are rejected.
module rotating_bitmap_id_allocator #(
   parameter int ID_COUNT      = 8192,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rbid_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rbid_pkg::rsp_type rsp_data
);
   import rbid_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller sequences each request; it sees the request only through status.
   rbid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // The datapath holds the bitmap, the cursor and the result register.
   rbid_datapath #(
      .ID_COUNT      (ID_COUNT),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
